// ===== rtl/ocm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocm_pkg
// Constants and the arctangent table for the omni chassis mixer.
// ----------------------------------------------------------------------------
package ocm_pkg;

  // Default build parameters
  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int CORDIC_STEPS_DEF    = 16;

  // Datapath widths
  localparam int RED_W  = 26;   // angle reduction magnitude
  localparam int Z_W    = 27;   // CORDIC angle, Q16 degrees
  localparam int XY_W   = 34;   // CORDIC vector, Q30
  localparam int MA_W   = 18;   // multiplier operand A
  localparam int MB_W   = 35;   // multiplier operand B
  localparam int ACC_W  = MA_W + MB_W;
  localparam int VEL_W  = 17;   // rotated speed
  localparam int STEP_W = 5;    // CORDIC step index

  // Configuration register indexes
  localparam logic [1:0] REG_RADIUS_GAIN = 2'd0;
  localparam logic [1:0] REG_SPIN_RATE   = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0]        RADIUS_GAIN_RST = 16'd17210;
  localparam logic signed [15:0] SPIN_RATE_RST   = 16'sd10000;
  localparam logic [7:0]         HOLD_TICKS_RST  = 8'd40;

  // Input modes
  localparam logic [1:0] MODE_ZERO_FORCE = 2'd0;
  localparam logic [1:0] MODE_NO_FOLLOW  = 2'd1;
  localparam logic [1:0] MODE_FOLLOW     = 2'd2;
  localparam logic [1:0] MODE_SPIN       = 2'd3;

  // Revive phases
  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_START  = 2'd1;
  localparam logic [1:0] PH_HOLD   = 2'd2;

  // Fixed-point constants
  localparam logic signed [Z_W-1:0]   QUARTER_TURN = 27'sd5898240;   // 90 deg, Q16
  localparam logic signed [Z_W-1:0]   HALF_TURN    = 27'sd11796480;  // 180 deg, Q16
  localparam logic signed [XY_W-1:0]  CORDIC_INIT  = 34'sd652032874; // 0.6072529350, Q30
  localparam logic signed [MB_W-1:0]  DIAG_GAIN    = 35'sd46341;     // 0.7071, Q0.16
  localparam logic signed [ACC_W-1:0] RND30        = 53'sd536870912;
  localparam logic signed [ACC_W-1:0] RND16        = 53'sd32768;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/omni_chassis_mixer_with_revive_hold_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_chassis_mixer_with_revive_hold_unit
// X-layout omni chassis mixer: wraps the gimbal offset, rotates the command
// with an iterative CORDIC, mixes in the rotation rate through one shared
// multiplier and applies the post-revive zero-output hold.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  tick     | tick_valid, tick_stall, mode .. permit    | in
//  wheel    | wheel_valid, wheel_stall, wheel_* , flags | out
//  config   | cfg_write, cfg_index, cfg_data            | in
//
//  A request runs from accept to the next accept through angle reduction
//  (one compare-subtract a cycle), the fold and quadrant setup states,
//  one CORDIC rotation a cycle, the product sequence through the shared
//  multiplier, a state to post the result once the output is free and
//  the idle state in which the next request is taken.
//  tick_stall is high while a request is at work. A stalled result is kept
//  in the output register; the next request may run behind it.
//  Reset (rst, synchronous) clears the sequencer, the revive state and the
//  configuration registers to their defaults.
// ----------------------------------------------------------------------------
module omni_chassis_mixer_with_revive_hold_unit
  import ocm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // tick channel
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic [1:0]         mode,
  input  logic signed [15:0] speed_x,
  input  logic signed [15:0] speed_y,
  input  logic signed [23:0] gimbal_offset,
  input  logic signed [15:0] follow_rate,
  input  logic               referee_present,
  input  logic [15:0]        hit_points,
  input  logic               output_permit,
  // wheel channel
  output logic               wheel_valid,
  input  logic               wheel_stall,
  output logic signed [15:0] wheel_left_front,
  output logic signed [15:0] wheel_right_front,
  output logic signed [15:0] wheel_left_back,
  output logic signed [15:0] wheel_right_back,
  output logic               motors_enabled,
  output logic               hold_active
);

  // Angle reduction constants
  localparam int FULL_DEG = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_DEG = 180 << ANGLE_FRAC_BITS;
  localparam int KTOP     = $clog2((2 ** 23) / FULL_DEG + 1);
  localparam int KCNT_W   = $clog2(KTOP + 1);
  localparam int Q_SHIFT  = 16 - ANGLE_FRAC_BITS;
  localparam logic [RED_W-1:0] FULL_R = RED_W'(FULL_DEG);
  localparam logic [RED_W-1:0] HALF_R = RED_W'(HALF_DEG);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WRAP = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_QUAD = 3'd3;
  localparam logic [2:0] ST_ROT  = 3'd4;
  localparam logic [2:0] ST_MAC  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // Multiplier sequence steps
  localparam logic [3:0] MS_XC   = 4'd0;
  localparam logic [3:0] MS_YS   = 4'd1;
  localparam logic [3:0] MS_XS   = 4'd2;
  localparam logic [3:0] MS_YC   = 4'd3;
  localparam logic [3:0] MS_ROT  = 4'd4;
  localparam logic [3:0] MS_LF   = 4'd5;
  localparam logic [3:0] MS_RF   = 4'd6;
  localparam logic [3:0] MS_LB   = 4'd7;
  localparam logic [3:0] MS_RB   = 4'd8;
  localparam logic [3:0] MS_LAST = 4'd9;

  // Configuration registers
  logic [15:0]        radius_gain;
  logic signed [15:0] spin_rate;
  logic [7:0]         hold_ticks;

  // Control state
  logic [2:0]        state;
  logic [KCNT_W-1:0] kcnt;
  logic [STEP_W-1:0] step;
  logic [3:0]        mstep;
  logic              prev_permitted;
  logic [1:0]        revive_phase;
  logic [7:0]        revive_count;

  // Request payload
  logic signed [15:0] sx, sy, wz;
  logic               neg_z, hold, motors_en;
  logic [RED_W-1:0]   mag;

  // Datapath
  logic signed [Z_W-1:0]   z;
  logic                    flip;
  logic signed [XY_W-1:0]  x, y;
  logic signed [ACC_W-1:0] acc;
  logic signed [VEL_W-1:0] vx, vy;
  logic signed [XY_W-1:0]  rot;
  logic signed [15:0]      wres [4];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_gain <= RADIUS_GAIN_RST;
      spin_rate   <= SPIN_RATE_RST;
      hold_ticks  <= HOLD_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS_GAIN: radius_gain <= cfg_data;
        REG_SPIN_RATE:   spin_rate   <= cfg_data;
        REG_HOLD_TICKS:  hold_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic tick_take, out_free;
  assign tick_stall = (state != ST_IDLE);
  assign tick_take  = tick_valid && !tick_stall;
  assign out_free   = !wheel_valid || !wheel_stall;

  // Permission edge and revive hold progress
  logic       permitted;
  logic [1:0] ph_a, ph_next;
  logic [7:0] cnt_a, cnt_next;
  always_comb begin
    permitted = !referee_present || (hit_points != 16'd0 && output_permit);
    if (permitted && !prev_permitted) begin
      ph_a  = PH_START;
      cnt_a = 8'd0;
    end else begin
      ph_a  = revive_phase;
      cnt_a = revive_count;
    end
    ph_next  = ph_a;
    cnt_next = cnt_a;
    if (ph_a == PH_START || ph_a == PH_HOLD) begin
      cnt_next = cnt_a + 8'd1;
      if (cnt_a >= 8'd2) begin
        if (cnt_next >= hold_ticks) begin
          ph_next  = PH_NORMAL;
          cnt_next = 8'd0;
        end else begin
          ph_next = PH_HOLD;
        end
      end
    end
  end

  // Magnitude of the raw offset; the most negative value fits in 25 bits
  logic signed [24:0] ang_ext, ang_abs;
  assign ang_ext = {gimbal_offset[23], gimbal_offset};
  assign ang_abs = ang_ext[24] ? -ang_ext : ang_ext;

  // Reduction step: subtract FULL << kcnt when it fits
  logic [RED_W-1:0] red_sub;
  assign red_sub = FULL_R << kcnt;

  // Fold reduced magnitude to +-180 deg, scale to Q16, apply sign
  logic signed [RED_W:0] fold_v;
  logic signed [Z_W-1:0] z_fold;
  always_comb begin
    fold_v = (mag > HALF_R) ? ($signed({1'b0, mag}) - $signed({1'b0, FULL_R}))
                            : $signed({1'b0, mag});
    z_fold = Z_W'(fold_v) <<< Q_SHIFT;
    if (neg_z) z_fold = -z_fold;
  end

  // CORDIC rotation step
  logic signed [XY_W-1:0] x_sh, y_sh, x_rot, y_rot;
  logic signed [Z_W-1:0]  atan_v, z_rot;
  logic                   rot_last;
  always_comb begin
    x_sh   = x >>> step;
    y_sh   = y >>> step;
    atan_v = $signed(Z_W'(atan_q16(step)));
    if (z >= 0) begin
      x_rot = x - y_sh;
      y_rot = y + x_sh;
      z_rot = z - atan_v;
    end else begin
      x_rot = x + y_sh;
      y_rot = y - x_sh;
      z_rot = z + atan_v;
    end
    rot_last = (step == STEP_W'(CORDIC_STEPS - 1));
  end

  // Shared multiplier operand select
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] prod;
  logic signed [MA_W-1:0]  vxe, vye;
  assign vxe = MA_W'(vx);
  assign vye = MA_W'(vy);
  always_comb begin
    unique case (mstep)
      MS_XC:   begin mul_a = MA_W'(sx);  mul_b = MB_W'(x); end
      MS_YS:   begin mul_a = MA_W'(sy);  mul_b = MB_W'(y); end
      MS_XS:   begin mul_a = MA_W'(sx);  mul_b = MB_W'(y); end
      MS_YC:   begin mul_a = MA_W'(sy);  mul_b = MB_W'(x); end
      MS_ROT:  begin mul_a = MA_W'(wz);  mul_b = $signed({{(MB_W-16){1'b0}}, radius_gain}); end
      MS_LF:   begin mul_a = -vxe - vye; mul_b = DIAG_GAIN; end
      MS_RF:   begin mul_a = -vxe + vye; mul_b = DIAG_GAIN; end
      MS_LB:   begin mul_a = vxe - vye;  mul_b = DIAG_GAIN; end
      MS_RB:   begin mul_a = vxe + vye;  mul_b = DIAG_GAIN; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Rounded wheel value from the accumulator, saturated to 16 bits
  logic signed [ACC_W-17:0] wsh;
  logic signed [15:0]       wsat;
  always_comb begin
    wsh = acc[ACC_W-1:16];
    if (wsh > 37'sd32767)       wsat = 16'sh7fff;
    else if (wsh < -37'sd32768) wsat = 16'sh8000;
    else                        wsat = wsh[15:0];
  end

  logic signed [ACC_W-1:0] mix_offset;
  assign mix_offset = RND16 - ACC_W'(rot);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      prev_permitted <= 1'b0;
      revive_phase   <= PH_NORMAL;
      revive_count   <= 8'd0;
      wheel_valid    <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        wheel_valid <= 1'b1;
      end else if (wheel_valid && !wheel_stall) begin
        wheel_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (tick_take) begin
            prev_permitted <= permitted;
            revive_phase   <= ph_next;
            revive_count   <= cnt_next;
            state          <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (kcnt == '0) state <= ST_FOLD;
        end
        ST_FOLD: state <= ST_QUAD;
        ST_QUAD: state <= ST_ROT;
        ST_ROT: begin
          if (rot_last) state <= ST_MAC;
        end
        ST_MAC: begin
          if (mstep == MS_LAST) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload and arithmetic registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (tick_take) begin
          if (mode == MODE_ZERO_FORCE) begin
            sx <= '0;
            sy <= '0;
          end else begin
            sx <= speed_x;
            sy <= speed_y;
          end
          case (mode)
            MODE_FOLLOW: wz <= follow_rate;
            MODE_SPIN:   wz <= spin_rate;
            default:     wz <= '0;
          endcase
          motors_en <= (mode != MODE_ZERO_FORCE);
          hold      <= (ph_next == PH_HOLD);
          neg_z     <= gimbal_offset[23] ^ (mode == MODE_FOLLOW);
          mag       <= {1'b0, ang_abs};
          kcnt      <= KCNT_W'(KTOP);
        end
      end
      ST_WRAP: begin
        if (mag >= red_sub) mag <= mag - red_sub;
        kcnt <= kcnt - 1'b1;
      end
      ST_FOLD: z <= z_fold;
      ST_QUAD: begin
        if (z > QUARTER_TURN) begin
          z    <= z - HALF_TURN;
          flip <= 1'b1;
        end else if (z < -QUARTER_TURN) begin
          z    <= z + HALF_TURN;
          flip <= 1'b1;
        end else begin
          flip <= 1'b0;
        end
        x    <= CORDIC_INIT;
        y    <= '0;
        step <= '0;
      end
      ST_ROT: begin
        z    <= z_rot;
        step <= step + 1'b1;
        if (rot_last && flip) begin
          x <= -x_rot;
          y <= -y_rot;
        end else begin
          x <= x_rot;
          y <= y_rot;
        end
        mstep <= MS_XC;
      end
      ST_MAC: begin
        mstep <= mstep + 4'd1;
        case (mstep)
          MS_XC: acc <= RND30 + prod;
          MS_YS: acc <= acc + prod;
          MS_XS: begin
            vx  <= acc[30 +: VEL_W];
            acc <= RND30 - prod;
          end
          MS_YC: acc <= acc + prod;
          MS_ROT: begin
            vy  <= acc[30 +: VEL_W];
            rot <= XY_W'(prod);
          end
          MS_LF: acc <= mix_offset + prod;
          MS_RF: begin
            wres[0] <= wsat;
            acc     <= mix_offset + prod;
          end
          MS_LB: begin
            wres[1] <= wsat;
            acc     <= mix_offset + prod;
          end
          MS_RB: begin
            wres[2] <= wsat;
            acc     <= mix_offset + prod;
          end
          default: wres[3] <= wsat;
        endcase
      end
      default: ;
    endcase
  end

  // Output register, loaded when the previous result is gone
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      wheel_left_front  <= hold ? 16'sd0 : wres[0];
      wheel_right_front <= hold ? 16'sd0 : wres[1];
      wheel_left_back   <= hold ? 16'sd0 : wres[2];
      wheel_right_back  <= hold ? 16'sd0 : wres[3];
      motors_enabled    <= motors_en;
      hold_active       <= hold;
    end
  end

endmodule

// ===== test/omni_chassis_mixer_with_revive_hold_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_chassis_mixer_with_revive_hold_unit_test
// Self-checking bench for the X-layout omni chassis mixer. A scoreboard
// predicts every wheel result from the accepted tick requests: offset wrap,
// CORDIC rotation, rate mixing, saturation and the post-revive hold. The
// stimulus is a directed set of corner cases, then random ticks under
// several register settings, with bursty ticks and random wheel stalls.
// ----------------------------------------------------------------------------
module omni_chassis_mixer_with_revive_hold_unit_test;
  import ocm_pkg::*;

  localparam int          ANG_FRAC    = ANGLE_FRAC_BITS_DEF;
  localparam int          CORDIC_N    = CORDIC_STEPS_DEF;
  localparam longint      HALF_IN     = longint'(180) << ANG_FRAC;
  localparam longint      FULL_IN     = longint'(360) << ANG_FRAC;
  localparam int          QUARTER_IN  = 90 << ANG_FRAC;
  localparam longint      ANG_SCALE   = longint'(1) << (16 - ANG_FRAC);
  localparam longint      ROUND30     = longint'(1) << 29;
  localparam longint      ROUND16     = longint'(1) << 15;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int          IDLE_PAD    = 60;
  localparam int          PHASE_TICKS = 330;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          MAX_REPORTS = 40;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [23:0] gimbal_offset;
    logic signed [15:0] follow_rate;
    logic               referee_present;
    logic [15:0]        hit_points;
    logic               output_permit;
  } tick_t;

  typedef struct {
    logic signed [15:0] lf;
    logic signed [15:0] rf;
    logic signed [15:0] lb;
    logic signed [15:0] rb;
    logic               motors;
    logic               hold;
  } wheel_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_level_t;

  // Predicts wheel results and checks them in order
  class mixer_scoreboard;
    logic [15:0]        radius_gain;
    logic signed [15:0] spin_rate;
    logic [7:0]         hold_ticks;
    bit                 was_permitted;
    logic [1:0]         revive_phase;
    logic [7:0]         revive_count;
    longint             atan_deg[24];
    wheel_t             pending_wheels[$];
    int                 errors;
    int                 ticks;
    int                 checked;
    int                 holds;

    function new();
      radius_gain   = RADIUS_GAIN_RST;
      spin_rate     = SPIN_RATE_RST;
      hold_ticks    = HOLD_TICKS_RST;
      was_permitted = 1'b0;
      revive_phase  = PH_NORMAL;
      revive_count  = '0;
      // atan(2^-i) in Q16 degrees
      atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
      errors  = 0;
      ticks   = 0;
      checked = 0;
      holds   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_RADIUS_GAIN: radius_gain = data;
        REG_SPIN_RATE:   spin_rate = data;
        REG_HOLD_TICKS:  hold_ticks = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_tick(tick_t t);
      longint sx, sy, rate, a_raw, ang, z, x, y, nx, vx, vy, gain, rot, v;
      longint sum[4];
      logic signed [15:0] out[4];
      bit permitted, flip, hold;
      wheel_t e;
      int i;

      // revive edge and hold sequencing
      permitted = !t.referee_present || (t.hit_points != 0 && t.output_permit);
      if (permitted && !was_permitted) begin
        revive_phase = PH_START;
        revive_count = '0;
      end
      was_permitted = permitted;
      if (revive_phase == PH_START || revive_phase == PH_HOLD) begin
        if (revive_count < 8'd2) begin
          revive_count = revive_count + 8'd1;
        end else begin
          revive_count = revive_count + 8'd1;
          if (revive_count >= hold_ticks) begin
            revive_phase = PH_NORMAL;
            revive_count = '0;
          end else begin
            revive_phase = PH_HOLD;
          end
        end
      end
      hold = (revive_phase == PH_HOLD);

      // command and rotation rate by mode
      sx = t.speed_x;
      sy = t.speed_y;
      case (t.mode)
        MODE_ZERO_FORCE: begin
          sx = 0;
          sy = 0;
          rate = 0;
        end
        MODE_NO_FOLLOW: rate = 0;
        MODE_FOLLOW:    rate = t.follow_rate;
        default:        rate = spin_rate;
      endcase

      // wrap to +-180 deg; the boundary keeps the sign of the raw angle
      a_raw = t.gimbal_offset;
      ang = a_raw % FULL_IN;
      if (ang < 0) ang += FULL_IN;
      if (ang > HALF_IN) ang -= FULL_IN;
      if (ang == HALF_IN && a_raw < 0) ang = -HALF_IN;
      z = ang * ANG_SCALE;
      if (t.mode == MODE_FOLLOW) z = -z;

      // CORDIC with a half-turn fold
      x = CORDIC_INIT;
      y = 0;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
        z -= HALF_TURN;
        flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z += HALF_TURN;
        flip = 1'b1;
      end
      for (i = 0; i < CORDIC_N && i < 24; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  -= atan_deg[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  += atan_deg[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end

      // rotate into the chassis frame and mix the wheels
      vx = (sx * x + sy * y + ROUND30) >>> 30;
      vy = (-sx * y + sy * x + ROUND30) >>> 30;
      gain = radius_gain;
      rot = rate * gain;
      sum[0] = (-vx - vy) * DIAG_GAIN - rot;
      sum[1] = (-vx + vy) * DIAG_GAIN - rot;
      sum[2] = (vx - vy) * DIAG_GAIN - rot;
      sum[3] = (vx + vy) * DIAG_GAIN - rot;
      for (i = 0; i < 4; i++) begin
        v = (sum[i] + ROUND16) >>> 16;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        out[i] = hold ? 16'sd0 : 16'(v);
      end

      e.lf     = out[0];
      e.rf     = out[1];
      e.lb     = out[2];
      e.rb     = out[3];
      e.motors = (t.mode != MODE_ZERO_FORCE);
      e.hold   = hold;
      pending_wheels.push_back(e);
      ticks++;
      if (hold) holds++;
    endfunction

    function void cmp(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_wheels(wheel_t got);
      wheel_t want;
      if (pending_wheels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: wheel result with no tick pending, expected none, %s",
                   $time, $sformatf("actual %0d/%0d/%0d/%0d",
                                    got.lf, got.rf, got.lb, got.rb));
        return;
      end
      want = pending_wheels.pop_front();
      checked++;
      cmp("wheel_left_front", want.lf, got.lf);
      cmp("wheel_right_front", want.rf, got.rf);
      cmp("wheel_left_back", want.lb, got.lb);
      cmp("wheel_right_back", want.rb, got.rb);
      cmp("motors_enabled", want.motors, got.motors);
      cmp("hold_active", want.hold, got.hold);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               tick_valid;
  logic               tick_stall;
  logic [1:0]         mode;
  logic signed [15:0] speed_x;
  logic signed [15:0] speed_y;
  logic signed [23:0] gimbal_offset;
  logic signed [15:0] follow_rate;
  logic               referee_present;
  logic [15:0]        hit_points;
  logic               output_permit;
  logic               wheel_valid;
  logic               wheel_stall = 1'b0;
  logic signed [15:0] wheel_left_front;
  logic signed [15:0] wheel_right_front;
  logic signed [15:0] wheel_left_back;
  logic signed [15:0] wheel_right_back;
  logic               motors_enabled;
  logic               hold_active;

  mixer_scoreboard sb;
  tick_t           script[$];
  bit              want_permit = 1'b1;
  int              toggle_odds = 40;
  int              cfg_writes = 0;
  int unsigned     cycle_count = 0;
  stall_level_t    stall_level = STALL_NONE;
  int              stall_span = 0;

  omni_chassis_mixer_with_revive_hold_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .tick_valid        (tick_valid),
    .tick_stall        (tick_stall),
    .mode              (mode),
    .speed_x           (speed_x),
    .speed_y           (speed_y),
    .gimbal_offset     (gimbal_offset),
    .follow_rate       (follow_rate),
    .referee_present   (referee_present),
    .hit_points        (hit_points),
    .output_permit     (output_permit),
    .wheel_valid       (wheel_valid),
    .wheel_stall       (wheel_stall),
    .wheel_left_front  (wheel_left_front),
    .wheel_right_front (wheel_right_front),
    .wheel_left_back   (wheel_left_back),
    .wheel_right_back  (wheel_right_back),
    .motors_enabled    (motors_enabled),
    .hold_active       (hold_active)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, sb.pending_wheels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wheel-side stall: the level is drawn anew whenever its span runs out
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_level <= stall_level_t'($urandom_range(0, 3));
      stall_span  <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_level)
      STALL_NONE:  wheel_stall <= 1'b0;
      STALL_LIGHT: wheel_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: wheel_stall <= ($urandom_range(0, 3) != 0);
      default:     wheel_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // Wheel monitor
  always @(posedge clk) begin : wheel_monitor
    wheel_t got;
    if (!rst && wheel_valid && !wheel_stall) begin
      got.lf     = wheel_left_front;
      got.rf     = wheel_right_front;
      got.lb     = wheel_left_back;
      got.rb     = wheel_right_back;
      got.motors = motors_enabled;
      got.hold   = hold_active;
      sb.check_wheels(got);
    end
  end

  function automatic tick_t mk_tick(logic [1:0] m, int sx, int sy, int ang, int fr,
                                    bit pres, int hp, bit perm);
    tick_t t;
    t.mode            = m;
    t.speed_x         = 16'(sx);
    t.speed_y         = 16'(sy);
    t.gimbal_offset   = 24'(ang);
    t.follow_rate     = 16'(fr);
    t.referee_present = pres;
    t.hit_points      = 16'(hp);
    t.output_permit   = perm;
    return t;
  endfunction

  // Speeds and rates: extremes, small values near zero, or full range
  function automatic logic signed [15:0] pick16();
    int v;
    v = $urandom_range(0, 63);
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(v - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // Offsets: full range, near quarter-turn multiples, or within +-200 deg
  function automatic logic signed [23:0] pick_angle();
    int k, d, w;
    k = $urandom_range(0, 2912);
    d = $urandom_range(0, 4);
    w = $urandom_range(0, 400 << ANG_FRAC);
    case ($urandom_range(0, 7))
      0, 1:    return 24'($urandom());
      2, 3:    return 24'((k - 1456) * QUARTER_IN + d - 2);
      default: return 24'(w - (200 << ANG_FRAC));
    endcase
  endfunction

  // Random tick; permission mostly holds steady so holds run to their end
  function automatic tick_t gen_tick();
    tick_t t;
    if ($urandom_range(1, toggle_odds) == 1) want_permit = !want_permit;
    t.mode          = 2'($urandom_range(0, 3));
    t.speed_x       = pick16();
    t.speed_y       = pick16();
    t.gimbal_offset = pick_angle();
    t.follow_rate   = pick16();
    t.hit_points    = 16'($urandom());
    t.output_permit = 1'($urandom_range(0, 1));
    if (want_permit) begin
      t.referee_present = ($urandom_range(0, 2) != 0);
      if (t.referee_present) begin
        t.output_permit = 1'b1;
        if (t.hit_points == 0) t.hit_points = 16'd1;
      end
    end else begin
      t.referee_present = 1'b1;
      if ($urandom_range(0, 1) != 0) t.hit_points = '0;
      else t.output_permit = 1'b0;
    end
    return t;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Hold a request until the mixer takes it
  task automatic send_tick(input tick_t t);
    tick_valid      <= 1'b1;
    mode            <= t.mode;
    speed_x         <= t.speed_x;
    speed_y         <= t.speed_y;
    gimbal_offset   <= t.gimbal_offset;
    follow_rate     <= t.follow_rate;
    referee_present <= t.referee_present;
    hit_points      <= t.hit_points;
    output_permit   <= t.output_permit;
    do @(posedge clk); while (tick_stall);
    sb.note_tick(t);
  endtask

  // Bursts of requests with random gaps; scripted ticks go first
  task automatic drive_ticks(input int n);
    int sent, burst, k;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (k = 0; k < burst && sent < n; k++) begin
        if (script.size() != 0) send_tick(script.pop_front());
        else send_tick(gen_tick());
        sent++;
      end
      if ($urandom_range(0, 3) != 0 || sent >= n) begin
        tick_valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    while (sb.pending_wheels.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] gain, input logic [15:0] spin,
                           input logic [15:0] hold, input int odds);
    settle();
    write_reg(REG_RADIUS_GAIN, gain);
    write_reg(REG_SPIN_RATE, spin);
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_UNUSED, 16'($urandom()));
    toggle_odds = odds;
    drive_ticks(PHASE_TICKS);
  endtask

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    tick_valid      = 1'b0;
    mode            = MODE_ZERO_FORCE;
    speed_x         = '0;
    speed_y         = '0;
    gimbal_offset   = '0;
    follow_rate     = '0;
    referee_present = 1'b0;
    hit_points      = '0;
    output_permit   = 1'b0;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first ticks after reset: the edge fires and the default hold begins
    script.push_back(mk_tick(MODE_NO_FOLLOW, 32767, -32768, 0, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_SPIN, -32768, 32767, 11520, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_FOLLOW, 20000, 20000, 2880, 32767, 1, 100, 1));
    drive_ticks(script.size());

    // short hold cuts the running one; then corners of the datapath
    settle();
    write_reg(REG_HOLD_TICKS, 16'd2);
    script.push_back(mk_tick(MODE_NO_FOLLOW, 32767, 0, 0, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_NO_FOLLOW, -32768, -32768, 2880, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_NO_FOLLOW, 32767, 32767, -2880, 0, 0, 0, 0));
    // exactly +-180 deg, also in follow mode where the angle is negated
    script.push_back(mk_tick(MODE_FOLLOW, 32767, -32768, 11520, 32767, 0, 0, 0));
    script.push_back(mk_tick(MODE_FOLLOW, -32768, 32767, -11520, -32768, 0, 0, 0));
    script.push_back(mk_tick(MODE_NO_FOLLOW, 1000, 2000, 34560, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_NO_FOLLOW, 1000, 2000, -34560, 0, 0, 0, 0));
    // quarter-turn fold boundaries
    script.push_back(mk_tick(MODE_SPIN, 32767, 32767, 5760, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_SPIN, -32768, -32768, -5760, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_NO_FOLLOW, 12345, -23456, 5761, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_NO_FOLLOW, 12345, -23456, -5761, 0, 0, 0, 0));
    // offset field extremes
    script.push_back(mk_tick(MODE_NO_FOLLOW, 30000, -30000, 8388607, 0, 0, 0, 0));
    script.push_back(mk_tick(MODE_FOLLOW, -30000, 30000, -8388608, 0, 0, 0, 0));
    // zero force ignores the command and the rate
    script.push_back(mk_tick(MODE_ZERO_FORCE, 32767, -32768, 1234, 32767, 0, 0, 0));
    script.push_back(mk_tick(MODE_SPIN, 0, 0, 0, 0, 0, 0, 0));
    // permission: dead, revived, permit dropped, referee gone
    script.push_back(mk_tick(MODE_NO_FOLLOW, 500, 500, 23040, 0, 1, 0, 1));
    script.push_back(mk_tick(MODE_NO_FOLLOW, 500, -500, -1, 0, 1, 65535, 1));
    script.push_back(mk_tick(MODE_FOLLOW, 0, 0, 0, 32767, 1, 65535, 0));
    script.push_back(mk_tick(MODE_FOLLOW, 0, 0, 0, -32768, 0, 0, 0));
    script.push_back(mk_tick(MODE_SPIN, 32767, -32768, -11519, 0, 1, 1, 1));
    drive_ticks(script.size());

    // random ticks under several register settings
    run_phase(RADIUS_GAIN_RST, SPIN_RATE_RST, 16'(HOLD_TICKS_RST), 40);
    run_phase(16'd0, 16'h8000, 16'd3, 25);
    run_phase(16'hFFFF, 16'h7FFF, 16'd255, 300);
    run_phase(16'hFFFF, 16'h8000, 16'd4, 12);
    run_phase(16'($urandom()), 16'($urandom()),
              {8'($urandom()), 8'($urandom_range(0, 2))}, 3);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom_range(3, 60)), 50);

    settle();
    $display("Drove %0d ticks over six register settings with %0d register writes.",
             sb.ticks, cfg_writes);
    $display("Checked %0d wheel results, %0d of them inside the post-revive hold.",
             sb.checked, sb.holds);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
